// File: src/sgtr_pkg.sv
// sgtr_pkg: shared types, constants and the 5x7 glyph rom of the text renderer
// depends on nothing; imported by sgtr_row_mask, scaled_glyph_text_renderer, sgtr_row_checker and the testbench
`default_nettype none

package sgtr_pkg;

	localparam int GLYPH_ROWS    = 7;
	localparam int GLYPH_COLS    = 5;
	localparam int GLYPH_COUNT   = 70;
	localparam int ADVANCE_UNITS = 6;
	localparam int LINE_UNITS    = 8;
	localparam int MASK_W        = 40;
	localparam int COORD_W       = 16;
	localparam int COLOR_W       = 32;
	localparam int SCALE_REG_W   = 4;
	localparam int GIDX_W        = 7;
	localparam int ROW_W         = 3;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	localparam logic [7:0] CODE_NEWLINE = 8'd10;

	localparam logic [APB_ADDR_W-1:0] ADDR_PIXEL_SCALE = 3'd0;
	localparam logic [APB_ADDR_W-1:0] ADDR_DRAW_COLOR  = 3'd4;

	localparam logic MODE_BEGIN = 1'b0;
	localparam logic MODE_CHAR  = 1'b1;

	localparam logic [ROW_W-1:0] LAST_GLYPH_ROW = ROW_W'(GLYPH_ROWS - 1);

	typedef enum logic {
		ST_IDLE,
		ST_ROWS
	} state_t;

	typedef enum logic [1:0] {
		ADD_NONE,
		ADD_ADVANCE,
		ADD_LINE,
		ADD_ROW
	} add_sel_t;

	typedef struct packed {
		logic              hit;
		logic [GIDX_W-1:0] idx;
	} glyph_ref_t;

	localparam logic [4:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_ROWS] = '{
		'{5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E}, '{5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
		'{5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F}, '{5'h1F,5'h02,5'h04,5'h02,5'h01,5'h11,5'h0E},
		'{5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02}, '{5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E},
		'{5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E}, '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
		'{5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E}, '{5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C},
		'{5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11}, '{5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
		'{5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E}, '{5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E},
		'{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F}, '{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
		'{5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F}, '{5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
		'{5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E}, '{5'h07,5'h02,5'h02,5'h02,5'h12,5'h12,5'h0C},
		'{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11}, '{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
		'{5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11}, '{5'h11,5'h19,5'h19,5'h15,5'h13,5'h13,5'h11},
		'{5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E}, '{5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10},
		'{5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D}, '{5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11},
		'{5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E}, '{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
		'{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E}, '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04},
		'{5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11}, '{5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11},
		'{5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04}, '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F},
		'{5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F}, '{5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h1E},
		'{5'h00,5'h00,5'h0E,5'h10,5'h10,5'h10,5'h0E}, '{5'h01,5'h01,5'h0F,5'h11,5'h11,5'h11,5'h0F},
		'{5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0E}, '{5'h06,5'h09,5'h08,5'h1E,5'h08,5'h08,5'h08},
		'{5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h0E}, '{5'h10,5'h10,5'h16,5'h19,5'h11,5'h11,5'h11},
		'{5'h04,5'h00,5'h0C,5'h04,5'h04,5'h04,5'h0E}, '{5'h02,5'h00,5'h06,5'h02,5'h02,5'h12,5'h0C},
		'{5'h10,5'h10,5'h12,5'h14,5'h18,5'h14,5'h12}, '{5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
		'{5'h00,5'h00,5'h1A,5'h15,5'h15,5'h15,5'h11}, '{5'h00,5'h00,5'h16,5'h19,5'h11,5'h11,5'h11},
		'{5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E}, '{5'h00,5'h00,5'h1E,5'h11,5'h1E,5'h10,5'h10},
		'{5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h01}, '{5'h00,5'h00,5'h16,5'h19,5'h10,5'h10,5'h10},
		'{5'h00,5'h00,5'h0F,5'h10,5'h0E,5'h01,5'h1E}, '{5'h08,5'h08,5'h1E,5'h08,5'h08,5'h09,5'h06},
		'{5'h00,5'h00,5'h11,5'h11,5'h11,5'h13,5'h0D}, '{5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04},
		'{5'h00,5'h00,5'h11,5'h15,5'h15,5'h15,5'h0A}, '{5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11},
		'{5'h00,5'h00,5'h11,5'h11,5'h0F,5'h01,5'h0E}, '{5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F},
		'{5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C}, '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h08},
		'{5'h04,5'h04,5'h04,5'h04,5'h00,5'h04,5'h04}, '{5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04},
		'{5'h00,5'h04,5'h00,5'h00,5'h04,5'h04,5'h08}, '{5'h00,5'h04,5'h00,5'h04,5'h04,5'h08,5'h00},
		'{5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00}, '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F}
	};

	function automatic glyph_ref_t glyph_lookup(input logic [7:0] code);
		glyph_ref_t r;
		r.hit = 1'b1;
		r.idx = '0;
		case (code) inside
			[8'h30:8'h39]: r.idx = GIDX_W'(code - 8'h30);
			[8'h41:8'h5A]: r.idx = GIDX_W'(code - 8'h41 + 8'd10);
			[8'h61:8'h7A]: r.idx = GIDX_W'(code - 8'h61 + 8'd36);
			8'h2E:         r.idx = 7'd62;
			8'h2C:         r.idx = 7'd63;
			8'h21:         r.idx = 7'd64;
			8'h3F:         r.idx = 7'd65;
			8'h3A:         r.idx = 7'd66;
			8'h3B:         r.idx = 7'd67;
			8'h2D:         r.idx = 7'd68;
			8'h5F:         r.idx = 7'd69;
			default:       r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: src/scaled_glyph_text_renderer.sv
// scaled_glyph_text_renderer: 5x7 text character generator, one scaled row per word
// depends on sgtr_pkg and sgtr_row_mask
// flow: begin, newline, space and unknown codes are handled while idle; a glyph emits
// 7*scale rows, one output row per cycle while row_ready holds, paced by the
// row sequencer and its shared 16-bit coordinate adder; item_ready is low meanwhile
// reset: cursor, line start and output valid clear, pixel_scale 1, draw_color all ones
`default_nettype none

module scaled_glyph_text_renderer
	import sgtr_pkg::*;
#(
	parameter int MAX_SCALE = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire logic                  mode,
	input  wire logic [7:0]            char_code,
	input  wire logic [COORD_W-1:0]    start_x,
	input  wire logic [COORD_W-1:0]    start_y,
	output logic                       row_valid,
	input  wire logic                  row_ready,
	output logic      [COORD_W-1:0]    row_x,
	output logic      [COORD_W-1:0]    row_y,
	output logic      [MASK_W-1:0]     pixel_mask,
	output logic      [COLOR_W-1:0]    color,
	output logic                       last
);

	localparam int SCALE_W = $clog2(MAX_SCALE + 1);

	logic [SCALE_REG_W-1:0] pixel_scale_q;
	logic [COLOR_W-1:0]     draw_color_q;
	logic [COORD_W-1:0]     cursor_x_q;
	logic [COORD_W-1:0]     cursor_y_q;
	logic [COORD_W-1:0]     line_start_x_q;
	logic [COORD_W-1:0]     y_q;
	logic [GIDX_W-1:0]      gidx_q;
	logic [ROW_W-1:0]       row_q;
	logic [SCALE_W-1:0]     sub_q;
	logic                   row_valid_q;
	state_t                 state_q;
	state_t                 state_d;

	logic                   cfg_wr;
	logic [SCALE_W-1:0]     scale;
	logic                   accept;
	glyph_ref_t             gref;
	logic                   load_row;
	logic                   last_row;
	add_sel_t               add_sel;
	logic [COORD_W-1:0]     add_a;
	logic [COORD_W-1:0]     add_b;
	logic [COORD_W-1:0]     add_sum;
	logic [MASK_W-1:0]      mask;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr)
			ADDR_PIXEL_SCALE: prdata = APB_DATA_W'(pixel_scale_q);
			ADDR_DRAW_COLOR:  prdata = draw_color_q;
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_scale_q <= SCALE_REG_W'(1);
			draw_color_q  <= '1;
		end else if (cfg_wr) begin
			if (paddr == ADDR_PIXEL_SCALE) begin
				pixel_scale_q <= pwdata[SCALE_REG_W-1:0];
			end
			if (paddr == ADDR_DRAW_COLOR) begin
				draw_color_q <= pwdata[COLOR_W-1:0];
			end
		end
	end

	assign scale = (32'(pixel_scale_q) > MAX_SCALE) ? SCALE_W'(MAX_SCALE)
	                                                 : SCALE_W'(pixel_scale_q);

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign gref       = glyph_lookup(char_code);
	assign load_row   = (state_q == ST_ROWS) && (!row_valid_q || row_ready);
	assign last_row   = (row_q == LAST_GLYPH_ROW) && (sub_q == scale - SCALE_W'(1));

	// sequencer and adder operand select
	always_comb begin
		state_d = state_q;
		add_sel = ADD_NONE;
		case (state_q)
			ST_IDLE: begin
				if (accept && mode == MODE_CHAR && scale != '0) begin
					if (char_code == CODE_NEWLINE) begin
						add_sel = ADD_LINE;
					end else if (gref.hit) begin
						state_d = ST_ROWS;
					end else begin
						add_sel = ADD_ADVANCE;
					end
				end
			end
			ST_ROWS: begin
				if (load_row) begin
					if (last_row) begin
						add_sel = ADD_ADVANCE;
						state_d = ST_IDLE;
					end else begin
						add_sel = ADD_ROW;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// shared coordinate adder
	always_comb begin
		case (add_sel)
			ADD_ADVANCE: begin
				add_a = cursor_x_q;
				add_b = COORD_W'(ADVANCE_UNITS) * COORD_W'(scale);
			end
			ADD_LINE: begin
				add_a = cursor_y_q;
				add_b = COORD_W'(LINE_UNITS) * COORD_W'(scale);
			end
			ADD_ROW: begin
				add_a = y_q;
				add_b = COORD_W'(1);
			end
			default: begin
				add_a = y_q;
				add_b = '0;
			end
		endcase
	end

	assign add_sum = add_a + add_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			line_start_x_q <= '0;
		end else begin
			if (accept && mode == MODE_BEGIN) begin
				cursor_x_q     <= start_x;
				line_start_x_q <= start_x;
				cursor_y_q     <= start_y;
			end
			if (add_sel == ADD_LINE) begin
				cursor_x_q <= line_start_x_q;
				cursor_y_q <= add_sum;
			end
			if (add_sel == ADD_ADVANCE) begin
				cursor_x_q <= add_sum;
			end
		end
	end

	// row counters
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			gidx_q <= gref.idx;
			row_q  <= '0;
			sub_q  <= '0;
			y_q    <= cursor_y_q;
		end else if (load_row) begin
			y_q <= add_sum;
			if (sub_q == scale - SCALE_W'(1)) begin
				sub_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				sub_q <= sub_q + SCALE_W'(1);
			end
		end
	end

	sgtr_row_mask #(
		.MAX_SCALE(MAX_SCALE)
	) u_row_mask (
		.glyph_bits(GLYPH_ROM[gidx_q][row_q]),
		.scale     (scale),
		.pixel_mask(mask)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= 1'b0;
		end else if (load_row) begin
			row_valid_q <= 1'b1;
		end else if (row_ready) begin
			row_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_row) begin
			row_x      <= cursor_x_q;
			row_y      <= y_q;
			pixel_mask <= mask;
			color      <= draw_color_q;
			last       <= last_row;
		end
	end

	assign row_valid = row_valid_q;

endmodule

`default_nettype wire

// File: src/sgtr_row_mask.sv
// sgtr_row_mask: widens one 5-bit glyph row into a scaled pixel mask
// depends on sgtr_pkg
`default_nettype none

module sgtr_row_mask
	import sgtr_pkg::*;
#(
	parameter int MAX_SCALE = 8,
	localparam int SCALE_W  = $clog2(MAX_SCALE + 1)
) (
	input  wire logic [GLYPH_COLS-1:0] glyph_bits,
	input  wire logic [SCALE_W-1:0]    scale,
	output logic      [MASK_W-1:0]     pixel_mask
);

	localparam int POS_W = $clog2(GLYPH_COLS * MAX_SCALE + MAX_SCALE + 1) + 1;

	always_comb begin
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] hi;
		pixel_mask = '0;
		for (int p = 0; p < MASK_W; p++) begin
			for (int c = 0; c < GLYPH_COLS; c++) begin
				lo = POS_W'(c) * POS_W'(scale);
				hi = lo + POS_W'(scale);
				// column c is glyph bit 4-c, leftmost first
				if (glyph_bits[GLYPH_COLS-1-c] && (POS_W'(p) >= lo) && (POS_W'(p) < hi)) begin
					pixel_mask[p] = 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: test/sgtr_row_checker.sv
// sgtr_row_checker: follows the register writes and both word channels of the renderer,
// works out every scaled pixel row it owes and compares each row word as it leaves
// depends on sgtr_pkg for port widths, register addresses and mode codes
module sgtr_row_checker
	import sgtr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	input  logic                  item_valid,
	input  logic                  item_ready,
	input  logic                  mode,
	input  logic [7:0]            char_code,
	input  logic [COORD_W-1:0]    start_x,
	input  logic [COORD_W-1:0]    start_y,
	input  logic                  row_valid,
	input  logic                  row_ready,
	input  logic [COORD_W-1:0]    row_x,
	input  logic [COORD_W-1:0]    row_y,
	input  logic [MASK_W-1:0]     pixel_mask,
	input  logic [COLOR_W-1:0]    color,
	input  logic                  last,
	output int                    mismatch_count,
	output int                    rows_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOP_SCALE = 8;
	localparam int CHAR_STEP = 6;
	localparam int LINE_STEP = 8;
	localparam int NO_SLOT   = -1;

	// one glyph per entry, top row in the high byte, leftmost column is bit 4 of a row
	localparam logic [55:0] FONT [70] = '{
		56'h0E11131519110E, 56'h040C040404040E, 56'h0E11010204081F, 56'h1F02040201110E,
		56'h02060A121F0202, 56'h1F101E0101110E, 56'h0608101E11110E, 56'h1F010204080808,
		56'h0E11110E11110E, 56'h0E11110F01020C, 56'h0E11111F111111, 56'h1E11111E11111E,
		56'h0E11101010110E, 56'h1E11111111111E, 56'h1F10101E10101F, 56'h1F10101E101010,
		56'h0E11101711110F, 56'h1111111F111111, 56'h0E04040404040E, 56'h0702020212120C,
		56'h11121418141211, 56'h1010101010101F, 56'h111B1515111111, 56'h11191915131311,
		56'h0E11111111110E, 56'h1E11111E101010, 56'h0E11111115120D, 56'h1E11111E141211,
		56'h0F10100E01011E, 56'h1F040404040404, 56'h1111111111110E, 56'h11111111110A04,
		56'h11111115151B11, 56'h11110A040A1111, 56'h11110A04040404, 56'h1F01020408101F,
		56'h00000E010F110F, 56'h10101E1111111E, 56'h00000E1010100E, 56'h01010F1111110F,
		56'h00000E111F100E, 56'h0609081E080808, 56'h00000F110F010E, 56'h10101619111111,
		56'h04000C0404040E, 56'h0200060202120C, 56'h10101214181412, 56'h0C04040404040E,
		56'h00001A15151511, 56'h00001619111111, 56'h00000E1111110E, 56'h00001E111E1010,
		56'h00000F110F0101, 56'h00001619101010, 56'h00000F100E011E, 56'h08081E08080906,
		56'h0000111111130D, 56'h00001111110A04, 56'h0000111515150A, 56'h0000110A040A11,
		56'h000011110F010E, 56'h00001F0204081F, 56'h00000000000C0C, 56'h00000000000C08,
		56'h04040404000404, 56'h0E110102040004, 56'h00040000040408, 56'h00040004040800,
		56'h0000001F000000, 56'h0000000000001F
	};

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [MASK_W-1:0]  mask;
		logic [COLOR_W-1:0] paint;
		logic               final_row;
	} pixel_row_t;

	pixel_row_t glyph_rows_due [$];

	logic [COORD_W-1:0] cursor_x     = '0;
	logic [COORD_W-1:0] cursor_y     = '0;
	logic [COORD_W-1:0] margin_x     = '0;
	logic [3:0]         scale_reg    = 4'd1;
	logic [COLOR_W-1:0] color_reg    = '1;

	initial begin
		mismatch_count = 0;
		rows_due = 0;
	end

	function automatic int font_slot(input logic [7:0] code);
		if (code >= "0" && code <= "9")
			return int'(code) - int'("0");
		if (code >= "A" && code <= "Z")
			return 10 + int'(code) - int'("A");
		if (code >= "a" && code <= "z")
			return 36 + int'(code) - int'("a");
		case (code)
			".": return 62;
			",": return 63;
			"!": return 64;
			"?": return 65;
			":": return 66;
			";": return 67;
			"-": return 68;
			"_": return 69;
			default: return NO_SLOT;
		endcase
	endfunction

	function automatic logic [MASK_W-1:0] widen_row(input logic [4:0] bits, input int sc);
		logic [MASK_W-1:0] m;
		m = '0;
		for (int c = 0; c < 5; c++)
			if (bits[4 - c])
				for (int k = 0; k < sc; k++)
					m[c * sc + k] = 1'b1;
		return m;
	endfunction

	task automatic render_char();
		int sc;
		int slot;
		logic [4:0] bits;
		pixel_row_t r;
		if (mode == MODE_BEGIN) begin
			cursor_x = start_x;
			margin_x = start_x;
			cursor_y = start_y;
			return;
		end
		sc = (int'(scale_reg) > TOP_SCALE) ? TOP_SCALE : int'(scale_reg);
		if (sc == 0)
			return;
		if (char_code == CODE_NEWLINE) begin
			cursor_x = margin_x;
			cursor_y = cursor_y + 16'(LINE_STEP * sc);
			return;
		end
		slot = font_slot(char_code);
		if (slot != NO_SLOT) begin
			for (int g = 0; g < 7; g++) begin
				bits = FONT[slot][8 * (6 - g) +: 5];
				for (int s = 0; s < sc; s++) begin
					r.x = cursor_x;
					r.y = cursor_y + 16'(g * sc + s);
					r.mask = widen_row(bits, sc);
					r.paint = color_reg;
					r.final_row = (g == 6 && s == sc - 1);
					glyph_rows_due.push_back(r);
				end
			end
		end
		cursor_x = cursor_x + 16'(CHAR_STEP * sc);
	endtask

	task automatic compare_row();
		pixel_row_t e;
		if (glyph_rows_due.size() == 0) begin
			$error("row word with none expected: row_x %0h row_y %0h", row_x, row_y);
			mismatch_count++;
			return;
		end
		e = glyph_rows_due.pop_front();
		if (row_x !== e.x) begin
			$error("row_x: expected %0h, got %0h", e.x, row_x);
			mismatch_count++;
		end
		if (row_y !== e.y) begin
			$error("row_y: expected %0h, got %0h", e.y, row_y);
			mismatch_count++;
		end
		if (pixel_mask !== e.mask) begin
			$error("pixel_mask: expected %0h, got %0h", e.mask, pixel_mask);
			mismatch_count++;
		end
		if (color !== e.paint) begin
			$error("color: expected %0h, got %0h", e.paint, color);
			mismatch_count++;
		end
		if (last !== e.final_row) begin
			$error("last: expected %0b, got %0b", e.final_row, last);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x = '0;
			cursor_y = '0;
			margin_x = '0;
			scale_reg = 4'd1;
			color_reg = '1;
			glyph_rows_due.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_PIXEL_SCALE)
					scale_reg = pwdata[3:0];
				else if (paddr == ADDR_DRAW_COLOR)
					color_reg = pwdata;
			end
			if (row_valid && row_ready)
				compare_row();
			if (item_valid && item_ready)
				render_char();
		end
		rows_due = glyph_rows_due.size();
	end

endmodule

// File: test/scaled_glyph_text_renderer_tb.sv
// scaled_glyph_text_renderer_tb: drives strings, scale and color settings into the renderer
// with random idling on both channels; sgtr_row_checker predicts and compares the rows
// depends on sgtr_pkg, scaled_glyph_text_renderer and sgtr_row_checker
module scaled_glyph_text_renderer_tb
	import sgtr_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 3000;
	localparam int ROW_HOLD    = 300;
	localparam int PHASE_ITEMS = 32;
	localparam int PHASES      = 13;
	localparam logic [7:0] SPACE_CODE = 8'h20;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  psel       = 1'b0;
	logic                  penable    = 1'b0;
	logic                  pwrite     = 1'b0;
	logic [APB_ADDR_W-1:0] paddr      = '0;
	logic [APB_DATA_W-1:0] pwdata     = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	logic                  mode       = MODE_BEGIN;
	logic [7:0]            char_code  = '0;
	logic [COORD_W-1:0]    start_x    = '0;
	logic [COORD_W-1:0]    start_y    = '0;
	logic                  row_valid;
	logic                  row_ready  = 1'b0;
	logic [COORD_W-1:0]    row_x;
	logic [COORD_W-1:0]    row_y;
	logic [MASK_W-1:0]     pixel_mask;
	logic [COLOR_W-1:0]    color;
	logic                  last;
	int                    mismatch_count;
	int                    rows_due;

	bit tx_stalls   = 1'b1;
	bit rx_stalls   = 1'b1;
	bit hold_rows   = 1'b0;
	bit hold_served = 1'b0;
	int quiet_cycles = 0;

	int unsigned phase_scale [PHASES] = '{8, 0, 15, 2, 9, 3, 1, 4, 5, 6, 7, 2, 1};
	logic [7:0] probe_codes [18] = '{"0", "9", "A", "Z", "a", "z", ".", ",", "!", "?",
		":", ";", "-", "_", SPACE_CODE, 8'h00, 8'hFF, 8'h80};

	scaled_glyph_text_renderer dut (.*);
	sgtr_row_checker checker_i (.*);

	always #5 clk = ~clk;

	always begin
		@(negedge clk);
		if (hold_rows && !hold_served) begin
			row_ready <= 1'b0;
			repeat (ROW_HOLD) @(negedge clk);
			hold_served = 1'b1;
		end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
			row_ready <= 1'b0;
			repeat ($urandom_range(1, 8) - 1) @(negedge clk);
		end else begin
			row_ready <= 1'b1;
		end
	end

	always @(posedge clk)
		if ((item_valid && item_ready) || (row_valid && row_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("FAIL");
		$finish;
	end

	task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_item(input logic m, input logic [7:0] code,
			input logic [15:0] x, input logic [15:0] y);
		int gap;
		@(negedge clk);
		if (tx_stalls && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		mode <= m;
		char_code <= code;
		start_x <= x;
		start_y <= y;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic send_char(input logic [7:0] code);
		send_item(MODE_CHAR, code, 16'($urandom), 16'($urandom));
	endtask

	task automatic send_begin(input logic [15:0] x, input logic [15:0] y);
		send_item(MODE_BEGIN, 8'($urandom), x, y);
	endtask

	// wait until no rows are due, then let the renderer settle
	task automatic drain_rows();
		@(negedge clk);
		item_valid <= 1'b0;
		while (rows_due != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_glyph_code();
		int k;
		k = $urandom_range(0, 69);
		if (k < 10)
			return 8'("0" + k);
		if (k < 36)
			return 8'("A" + k - 10);
		if (k < 62)
			return 8'("a" + k - 36);
		case (k)
			62: return ".";
			63: return ",";
			64: return "!";
			65: return "?";
			66: return ":";
			67: return ";";
			68: return "-";
			default: return "_";
		endcase
	endfunction

	initial begin
		int pick;
		logic [31:0] paint;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		send_begin(16'h0000, 16'h0000);
		foreach (probe_codes[i])
			send_char(probe_codes[i]);
		send_char(CODE_NEWLINE);
		send_begin(16'hFFFF, 16'hFFFF);
		send_char("W");
		send_char(CODE_NEWLINE);
		send_char("M");

		for (int p = 0; p < PHASES; p++) begin
			drain_rows();
			paint = (p == 0) ? 32'h0 : (p == 2) ? 32'hFFFF_FFFF : $urandom;
			write_reg(ADDR_PIXEL_SCALE, phase_scale[p]);
			write_reg(ADDR_DRAW_COLOR, paint);
			tx_stalls = (p < PHASES - 2) && (p % 3 != 1);
			rx_stalls = (p < PHASES - 2) && (p % 3 != 2);
			if (p == 3)
				hold_rows = 1'b1;
			send_begin(16'($urandom), 16'($urandom));
			repeat ((phase_scale[p] == 0) ? 9 : PHASE_ITEMS - 1) begin
				pick = $urandom_range(0, 99);
				if (pick < 6)
					send_begin(16'($urandom), 16'($urandom));
				else if (pick < 12)
					send_char(CODE_NEWLINE);
				else if (pick < 20)
					send_char(SPACE_CODE);
				else if (pick < 26)
					send_char(8'($urandom_range(0, 255)));
				else
					send_char(pick_glyph_code());
			end
		end

		drain_rows();
		repeat (64) @(negedge clk);
		if (mismatch_count == 0 && rows_due == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
src/sgtr_pkg.sv
src/sgtr_row_mask.sv
src/scaled_glyph_text_renderer.sv
test/sgtr_row_checker.sv
test/scaled_glyph_text_renderer_tb.sv
